FILE: rtl/register_bank_hazard_pipeline_timer_macros.svh
// Assertion macros for the register bank hazard pipeline timer checker.
// Expects signals clk and arst_n in the scope of each use.
`ifndef REGISTER_BANK_HAZARD_PIPELINE_TIMER_MACROS_SVH
`define REGISTER_BANK_HAZARD_PIPELINE_TIMER_MACROS_SVH

// same-cycle implication
`define RBHPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RBHPT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rbhpt_pkg.sv
// Shared types, constants and helpers of the register bank hazard pipeline timer.
// No dependencies.
`timescale 1ns / 1ps

package rbhpt_pkg;

	localparam int PIPE_STAGES_DEF = 14;
	localparam int THREADS_DEF     = 24;
	localparam int QUEUE_DEPTH     = 16;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int THR_W           = 5;
	localparam int REG_W           = 5;

	localparam logic [31:0] EVEN_BANK = 32'h5555_5554;
	localparam logic [31:0] ODD_BANK  = 32'hAAAA_AAAA;

	typedef struct packed {
		logic [THR_W-1:0] thread;
		logic [REG_W-1:0] s1;
		logic [REG_W-1:0] s2;
		logic [REG_W-1:0] d;
		logic             rd_read;
	} pl_t;

	typedef struct packed {
		logic valid;
		pl_t  pl;
	} instr_t;

	typedef struct packed {
		logic issue_valid;
		pl_t  pl;
	} issue_t;

	// first member is the top bit: issue_ready lands in bit 0
	typedef struct packed {
		logic [THR_W-1:0] retire_thread;
		logic             retire_valid;
		logic [1:0]       extra_cycles;
		logic             check_valid;
		logic             issue_dropped;
		logic             issue_ready;
	} res_t;

	typedef struct packed {
		logic dropped;
		logic inc_busy;
	} front_stat_t;

	typedef struct packed {
		logic             check_valid;
		logic [1:0]       extra_cycles;
		logic             retire_valid;
		logic [THR_W-1:0] retire_thread;
		logic             chk_busy;
	} rule_stat_t;

	// true when the mask has two or more bits set
	function automatic logic two_or_more(input logic [31:0] m);
		return |(m & (m - 32'd1));
	endfunction

endpackage

FILE: rtl/rbhpt_front.sv
// Incoming slot, circular stage queue and ready slot of the timer.
// Depends on rbhpt_pkg.
`timescale 1ns / 1ps

module rbhpt_front import rbhpt_pkg::*; #(
	parameter int PIPE_STAGES = PIPE_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  issue_t      iss,
	input  logic        chk_busy,
	output instr_t      rdy,
	output front_stat_t stat
);

	localparam logic [QPTR_W-1:0] REAR_INIT = QPTR_W'(PIPE_STAGES - 1);
	localparam logic [QPTR_W:0]   FILL_MAX  = (QPTR_W + 1)'(PIPE_STAGES - 1);
	localparam logic [QPTR_W-1:0] PTR_ONE   = QPTR_W'(1);

	logic                   inc_vld_q;
	pl_t                    inc_pl_q;
	logic [QUEUE_DEPTH-1:0] slot_vld_q;
	pl_t                    slot_pl_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      front_q;
	logic [QPTR_W-1:0]      rear_q;
	logic                   rdy_vld_q;
	pl_t                    rdy_pl_q;

	logic              ready_now;
	logic              take_issue;
	logic              inc1_vld;
	pl_t               inc1_pl;
	logic [QPTR_W-1:0] fill;
	logic              push;
	logic              pop;
	logic              bypass;
	logic              pop_vld;
	pl_t               pop_pl;

	always_comb begin
		ready_now  = !inc_vld_q && !chk_busy;
		take_issue = iss.issue_valid && ready_now;
		inc1_vld   = take_issue ? 1'b1 : inc_vld_q;
		inc1_pl    = take_issue ? iss.pl : inc_pl_q;
		fill       = rear_q - front_q;
		push       = {1'b0, fill} < FILL_MAX;
		pop        = !chk_busy;
		// entry written and read in the same beat
		bypass     = push && (rear_q == front_q);
		pop_vld    = bypass ? inc1_vld : slot_vld_q[front_q];
		pop_pl     = bypass ? inc1_pl : slot_pl_q[front_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_vld_q  <= 1'b0;
			slot_vld_q <= '0;
			front_q    <= '0;
			rear_q     <= REAR_INIT;
			rdy_vld_q  <= 1'b0;
		end else if (en) begin
			inc_vld_q <= inc1_vld && !push;
			if (push) begin
				slot_vld_q[rear_q] <= inc1_vld;
				rear_q             <= rear_q + PTR_ONE;
			end
			if (pop) begin
				rdy_vld_q <= pop_vld;
				front_q   <= front_q + PTR_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (take_issue)
				inc_pl_q <= iss.pl;
			if (push)
				slot_pl_q[rear_q] <= inc1_pl;
			if (pop)
				rdy_pl_q <= pop_pl;
		end
	end

	assign rdy.valid     = rdy_vld_q;
	assign rdy.pl        = rdy_pl_q;
	assign stat.dropped  = iss.issue_valid && !ready_now;
	assign stat.inc_busy = inc1_vld && !push;

endmodule

FILE: rtl/rbhpt_rule.sv
// Bank rule check stage, stall hold and per-thread last write record.
// Depends on rbhpt_pkg.
`timescale 1ns / 1ps

module rbhpt_rule import rbhpt_pkg::*; #(
	parameter int THREADS = THREADS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  instr_t     rdy,
	output logic       chk_busy,
	output rule_stat_t stat
);

	localparam int TIDX_W = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam logic [THR_W:0] THR_LIMIT = (THR_W + 1)'(THREADS);

	logic               chk_vld_q;
	pl_t                chk_pl_q;
	logic               hold_vld_q;
	pl_t                hold_pl_q;
	logic [1:0]         stall_q;
	logic [THREADS-1:0] lw_vld_q;
	logic [REG_W-1:0]   lw_reg_q [THREADS];

	logic              take;
	logic              c1_vld;
	pl_t               c1_pl;
	logic              do_chk;
	logic              c_known;
	logic [TIDX_W-1:0] c_idx;
	logic              lw_hit;
	logic [31:0]       rd_set;
	logic [1:0]        extra;
	logic [1:0]        stall1;
	logic              h1_vld;
	pl_t               h1_pl;
	logic              c2_vld;
	logic              retire;
	logic              h_known;
	logic [TIDX_W-1:0] h_idx;
	logic [1:0]        stall2;

	always_comb begin
		take    = !chk_vld_q;
		c1_vld  = take ? rdy.valid : chk_vld_q;
		c1_pl   = take ? rdy.pl : chk_pl_q;
		do_chk  = c1_vld && !hold_vld_q;
		c_known = {1'b0, c1_pl.thread} < THR_LIMIT;
		c_idx   = c1_pl.thread[TIDX_W-1:0];
		lw_hit  = c_known && lw_vld_q[c_idx];

		rd_set = (32'd1 << c1_pl.s1) | (32'd1 << c1_pl.s2);
		if (c1_pl.rd_read)
			rd_set = rd_set | (32'd1 << c1_pl.d);
		if (lw_hit)
			rd_set = rd_set | (32'd1 << lw_reg_q[c_idx]);
		extra = {1'b0, two_or_more(rd_set & EVEN_BANK)}
			+ {1'b0, two_or_more(rd_set & ODD_BANK)};

		stall1 = do_chk ? extra : stall_q;
		h1_vld = do_chk ? 1'b1 : hold_vld_q;
		h1_pl  = do_chk ? c1_pl : hold_pl_q;
		c2_vld = do_chk ? 1'b0 : c1_vld;

		retire  = h1_vld && (stall1 == 2'd0);
		h_known = {1'b0, h1_pl.thread} < THR_LIMIT;
		h_idx   = h1_pl.thread[TIDX_W-1:0];
		stall2  = (stall1 != 2'd0) ? stall1 - 2'd1 : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
			stall_q    <= 2'd0;
			lw_vld_q   <= '0;
		end else if (en) begin
			chk_vld_q  <= c2_vld;
			hold_vld_q <= h1_vld && !retire;
			stall_q    <= stall2;
			if (retire && h_known)
				lw_vld_q[h_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chk_pl_q  <= c1_pl;
			hold_pl_q <= h1_pl;
			if (retire && h_known)
				lw_reg_q[h_idx] <= h1_pl.d;
		end
	end

	assign chk_busy           = chk_vld_q;
	assign stat.check_valid   = do_chk;
	assign stat.extra_cycles  = do_chk ? extra : 2'd0;
	assign stat.retire_valid  = retire;
	assign stat.retire_thread = retire ? h1_pl.thread : '0;
	assign stat.chk_busy      = c2_vld;

endmodule

FILE: rtl/rbhpt_obuf.sv
// Two-entry output buffer: result register plus skid register.
// Depends on rbhpt_pkg.
`timescale 1ns / 1ps

module rbhpt_obuf import rbhpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t din,
	output logic out_valid,
	input  logic out_ready,
	output res_t dout
);

	logic main_vld_q;
	res_t main_q;
	logic skid_vld_q;
	res_t skid_q;
	logic take;

	assign take = main_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!main_vld_q) begin
				main_vld_q <= in_valid;
			end else if (take) begin
				main_vld_q <= skid_vld_q || in_valid;
				skid_vld_q <= skid_vld_q && in_valid;
			end else if (in_valid) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q) begin
			main_q <= din;
		end else if (take) begin
			main_q <= skid_vld_q ? skid_q : din;
			skid_q <= din;
		end else if (in_valid) begin
			skid_q <= din;
		end
	end

	assign in_ready  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign dout      = main_q;

endmodule

FILE: rtl/register_bank_hazard_pipeline_timer.sv
// Register bank hazard pipeline timer: each input beat is one clock tick of the
// modeled pipeline. The slave channel carries an optional issued instruction
// (tuser bit 0 marks it issued). Every accepted input beat yields exactly one
// result beat on the master channel with issue readiness, dropped-issue flag,
// bank check result and retirement.
// Result: valid the cycle after its input beat is accepted if no result is pending.
// Throughput: one beat per cycle while s_tready is high; all tick logic sits between
// the state registers and the result register, the queue read being a 16-way mux.
// Reset: the stage queue starts with PIPE_STAGES-1 bubbles, the incoming,
// check and hold slots are empty and no thread has a recorded write. No
// clearing pass runs; the first beat can be taken right after reset.
// Stall: results go into a two-entry buffer. With one result waiting the
// block still takes a beat; s_tready drops only when both entries are full.
// Model state advances only on accepted beats, so stalls never change results.
// Depends on rbhpt_pkg, rbhpt_front, rbhpt_rule, rbhpt_obuf.
`timescale 1ns / 1ps

module register_bank_hazard_pipeline_timer import rbhpt_pkg::*; #(
	parameter int PIPE_STAGES = PIPE_STAGES_DEF,
	parameter int THREADS     = THREADS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// thread[4:0], src_one[9:5], src_two[14:10], dest[19:15], reads_dest[20], zero[23:21]
	input  logic [23:0] s_tdata,
	// issue_valid[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// issue_ready[0], issue_dropped[1], check_valid[2], extra_cycles[4:3],
	// retire_valid[5], retire_thread[10:6], zero[15:11]
	output logic [15:0] m_tdata
);

	localparam int PAD_W = 16 - $bits(res_t);

	logic        en;
	issue_t      iss;
	instr_t      rdy;
	logic        chk_busy;
	front_stat_t fstat;
	rule_stat_t  rstat;
	res_t        res;
	res_t        dout;

	assign en               = s_tvalid && s_tready;
	assign iss.issue_valid  = s_tuser[0];
	assign iss.pl.thread    = s_tdata[4:0];
	assign iss.pl.s1        = s_tdata[9:5];
	assign iss.pl.s2        = s_tdata[14:10];
	assign iss.pl.d         = s_tdata[19:15];
	assign iss.pl.rd_read   = s_tdata[20];

	rbhpt_front #(
		.PIPE_STAGES(PIPE_STAGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.iss      (iss),
		.chk_busy (chk_busy),
		.rdy      (rdy),
		.stat     (fstat)
	);

	rbhpt_rule #(
		.THREADS(THREADS)
	) u_rule (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rdy      (rdy),
		.chk_busy (chk_busy),
		.stat     (rstat)
	);

	always_comb begin
		res.issue_ready   = !fstat.inc_busy && !rstat.chk_busy;
		res.issue_dropped = fstat.dropped;
		res.check_valid   = rstat.check_valid;
		res.extra_cycles  = rstat.extra_cycles;
		res.retire_valid  = rstat.retire_valid;
		res.retire_thread = rstat.retire_thread;
	end

	rbhpt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (en),
		.in_ready  (s_tready),
		.din       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (dout)
	);

	assign m_tdata = {{PAD_W{1'b0}}, dout};

endmodule

FILE: rtl/rbhpt_chk.sv
// Port-level checker for the register bank hazard pipeline timer, bound to the top.
// Depends on register_bank_hazard_pipeline_timer_macros.svh.
`timescale 1ns / 1ps
`include "register_bank_hazard_pipeline_timer_macros.svh"

module rbhpt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`RBHPT_ASSERT_NXT(a_hold_stalled, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "stalled result beat changed")
	`RBHPT_ASSERT_IMP(a_extra_needs_check, m_tvalid && (m_tdata[4:3] != 2'd0),
		m_tdata[2] && (m_tdata[4:3] != 2'd3), "stall count without check or out of range")
	`RBHPT_ASSERT_IMP(a_thread_zero_idle, m_tvalid && !m_tdata[5],
		m_tdata[10:6] == 5'd0, "retire thread set without retirement")
	`RBHPT_ASSERT_IMP(a_backpressure_full, !s_tready, m_tvalid,
		"input stalled with no result pending")

endmodule

bind register_bank_hazard_pipeline_timer rbhpt_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
